// ===== rtl/kts_pkg.sv =====
`timescale 1ns / 1ps
package kts_pkg;

    localparam int MAX_KEYS_DEF = 64;

    // input item modes
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    // classified operations handed from front to back
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_ORDER = 2'd2;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_KIND = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INCLUSIVE  = 8'd1;

    typedef struct packed {
        logic [1:0]         op;
        logic [31:0]        item_time;
        logic signed [31:0] key_value_x;
        logic signed [31:0] key_value_y;
    } t_cmd;

endpackage

// ===== rtl/kts_front.sv =====
`timescale 1ns / 1ps
module kts_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [1:0]        i_mode,
    input  logic [31:0]       i_item_time,
    input  logic signed [31:0] i_key_value_x,
    input  logic signed [31:0] i_key_value_y,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output kts_pkg::t_cmd     o_cmd
);

    kts_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    kts_pkg::t_cmd w_cmd;
    logic          w_in;
    logic          w_out;

    always_comb begin
        w_cmd.item_time   = i_item_time;
        w_cmd.key_value_x = i_key_value_x;
        w_cmd.key_value_y = i_key_value_y;
        case (i_mode)
            kts_pkg::MODE_CLEAR:  w_cmd.op = kts_pkg::OP_CLEAR;
            kts_pkg::MODE_APPEND: w_cmd.op = kts_pkg::OP_APPEND;
            kts_pkg::MODE_QUERY:  w_cmd.op = kts_pkg::OP_QUERY;
            default:              w_cmd.op = kts_pkg::OP_NOP;
        endcase
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_in        = i_push && !o_full;
    assign w_out       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (w_in) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_in) begin
                r_wp <= !r_wp;
            end
            if (w_out) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_in} - {1'b0, w_out};
        end
    end

endmodule

// ===== rtl/kts_back.sv =====
`timescale 1ns / 1ps
module kts_back #(
    parameter int MAX_KEYS = kts_pkg::MAX_KEYS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [kts_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_ready,
    input  kts_pkg::t_cmd                 i_cmd,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic                          o_sample_valid,
    output logic signed [31:0]            o_sample_x,
    output logic signed [31:0]            o_sample_y,
    output logic [1:0]                    o_status,
    output logic [$clog2(MAX_KEYS+1)-1:0] o_key_count
);

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_KEYS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_CMP  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [31:0] mem_t [MAX_KEYS];
    logic [31:0] mem_x [MAX_KEYS];
    logic [31:0] mem_y [MAX_KEYS];

    logic [2:0]        r_state;
    logic [CW-1:0]     r_count;
    logic [31:0]       r_last_t;
    logic              r_kind;
    logic              r_incl;
    logic [31:0]       r_q;
    logic [CW-1:0]     r_idx;
    logic [31:0]       r_rd_t;
    logic [31:0]       r_rd_x;
    logic [31:0]       r_rd_y;
    logic [31:0]       r_prev_t;
    logic [31:0]       r_prev_x;
    logic [31:0]       r_prev_y;
    logic [31:0]       r_cur_x;
    logic [31:0]       r_cur_y;
    logic [31:0]       r_span;
    logic [32:0]       r_rem;
    logic [16:0]       r_frac;
    logic [4:0]        r_dcnt;
    logic [49:0]       r_prod_x;
    logic [49:0]       r_prod_y;
    logic              r_neg_x;
    logic              r_neg_y;
    logic              r_res_valid;
    logic              r_res_sv;
    logic [31:0]       r_res_x;
    logic [31:0]       r_res_y;
    logic [1:0]        r_res_st;

    logic              w_take;
    logic              w_wr;
    logic              w_stop;
    logic [32:0]       w_trial;
    logic              w_ge;
    logic signed [32:0] w_dx;
    logic signed [32:0] w_dy;
    logic [32:0]       w_mag_x;
    logic [32:0]       w_mag_y;
    logic [31:0]       w_step_x;
    logic [31:0]       w_step_y;

    assign o_cmd_ready    = (r_state == ST_IDLE) && !r_res_valid;
    assign w_take         = i_cmd_valid && o_cmd_ready;
    assign w_wr           = w_take && (i_cmd.op == kts_pkg::OP_APPEND) && (r_count < CNT_MAX)
                            && !((r_count != '0) && (i_cmd.item_time < r_last_t));
    assign o_empty        = !r_res_valid;
    assign o_sample_valid = r_res_sv;
    assign o_sample_x     = r_res_x;
    assign o_sample_y     = r_res_y;
    assign o_status       = r_res_st;
    assign o_key_count    = r_count;

    assign w_stop  = r_incl ? (r_q <= r_rd_t) : (r_q < r_rd_t);
    // first quotient bit (weight of one) is tested without a shift
    assign w_trial = (r_dcnt == 5'd0) ? r_rem : {r_rem[31:0], 1'b0};
    assign w_ge    = (w_trial >= {1'b0, r_span});

    assign w_dx    = $signed({r_cur_x[31], r_cur_x}) - $signed({r_prev_x[31], r_prev_x});
    assign w_dy    = $signed({r_cur_y[31], r_cur_y}) - $signed({r_prev_y[31], r_prev_y});
    assign w_mag_x = w_dx[32] ? 33'(-w_dx) : 33'(w_dx);
    assign w_mag_y = w_dy[32] ? 33'(-w_dy) : 33'(w_dy);
    assign w_step_x = r_prod_x[47:16];
    assign w_step_y = r_prod_y[47:16];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            mem_t[r_count[AW-1:0]] <= i_cmd.item_time;
            mem_x[r_count[AW-1:0]] <= i_cmd.key_value_x;
            mem_y[r_count[AW-1:0]] <= i_cmd.key_value_y;
        end
        r_rd_t <= mem_t[r_idx[AW-1:0]];
        r_rd_x <= mem_x[r_idx[AW-1:0]];
        r_rd_y <= mem_y[r_idx[AW-1:0]];
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_q <= i_cmd.item_time;
        end
        if (w_wr) begin
            r_last_t <= i_cmd.item_time;
        end
        if (r_state == ST_CMP) begin
            if (!w_stop) begin
                r_prev_t <= r_rd_t;
                r_prev_x <= r_rd_x;
                r_prev_y <= r_rd_y;
            end
            r_cur_x <= r_rd_x;
            r_cur_y <= r_rd_y;
            r_span  <= r_rd_t - r_prev_t;
            r_rem   <= {1'b0, r_q - r_prev_t};
            r_frac  <= '0;
            r_dcnt  <= '0;
        end
        if (r_state == ST_DIV) begin
            r_rem  <= w_ge ? (w_trial - {1'b0, r_span}) : w_trial;
            r_frac <= {r_frac[15:0], w_ge};
            r_dcnt <= r_dcnt + 5'd1;
        end
        if (r_state == ST_MUL) begin
            r_prod_x <= w_mag_x * r_frac;
            r_prod_y <= w_mag_y * r_frac;
            r_neg_x  <= w_dx[32];
            r_neg_y  <= w_dy[32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_kind      <= 1'b1;
            r_incl      <= 1'b0;
            r_idx       <= '0;
            r_res_valid <= 1'b0;
            r_res_sv    <= 1'b0;
            r_res_x     <= '0;
            r_res_y     <= '0;
            r_res_st    <= kts_pkg::STATUS_OK;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == kts_pkg::CFG_TRACK_KIND) begin
                    r_kind <= i_cfg_data[0];
                end else if (i_cfg_index == kts_pkg::CFG_INCLUSIVE) begin
                    r_incl <= i_cfg_data[0];
                end
            end
            if (i_pop && r_res_valid) begin
                r_res_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_take) begin
                        r_res_sv <= 1'b0;
                        r_res_x  <= '0;
                        r_res_y  <= '0;
                        r_res_st <= kts_pkg::STATUS_OK;
                        r_idx    <= '0;
                        case (i_cmd.op)
                            kts_pkg::OP_CLEAR: begin
                                r_count     <= '0;
                                r_res_valid <= 1'b1;
                            end
                            kts_pkg::OP_APPEND: begin
                                r_res_valid <= 1'b1;
                                if (r_count >= CNT_MAX) begin
                                    r_res_st <= kts_pkg::STATUS_FULL;
                                end else if (!w_wr) begin
                                    r_res_st <= kts_pkg::STATUS_ORDER;
                                end else begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            kts_pkg::OP_QUERY: begin
                                if (r_count == '0) begin
                                    r_res_valid <= 1'b1;
                                end else begin
                                    r_state <= ST_RD;
                                end
                            end
                            default: begin
                                r_res_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_RD: begin
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    if (w_stop) begin
                        if (r_idx == '0) begin
                            r_res_valid <= 1'b1;
                            r_state     <= ST_IDLE;
                        end else if (!r_kind) begin
                            r_res_valid <= 1'b1;
                            r_res_sv    <= 1'b1;
                            r_res_x     <= r_prev_x;
                            r_res_y     <= r_prev_y;
                            r_state     <= ST_IDLE;
                        end else if ((r_rd_t > r_prev_t) && (r_q >= r_prev_t)) begin
                            r_state <= ST_DIV;
                        end else begin
                            r_state <= ST_MUL;   // zero weight
                        end
                    end else if (r_idx + 1'b1 == r_count) begin
                        // past the last key
                        r_res_valid <= 1'b1;
                        r_res_sv    <= 1'b1;
                        r_res_x     <= r_rd_x;
                        r_res_y     <= r_rd_y;
                        r_state     <= ST_IDLE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_RD;
                    end
                end
                ST_DIV: begin
                    if (r_dcnt == 5'd16) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    r_res_valid <= 1'b1;
                    r_res_sv    <= 1'b1;
                    r_res_x     <= r_neg_x ? (r_prev_x - w_step_x) : (r_prev_x + w_step_x);
                    r_res_y     <= r_neg_y ? (r_prev_y - w_step_y) : (r_prev_y + w_step_y);
                    r_state     <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/keyframe_track_sampler_top.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake                    payload
// input     in         i_push / o_full              i_mode, i_item_time, i_key_value_x/y
// result    out        o_empty / i_pop              o_sample_valid, o_sample_x/y, o_status
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// A query visits keys one by one through the registered key memory read, then runs the
// bit-serial weight divider and the blend multiply when it interpolates. The front
// queue holds two items; one result register.
// Reset (synchronous, active low) empties both queues, the key table and sets
// linear interpolation with strict compare. The engine takes no item while a result waits.
module keyframe_track_sampler_top #(
    parameter int MAX_KEYS = kts_pkg::MAX_KEYS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [1:0]                    i_mode,
    input  logic [31:0]                   i_item_time,
    input  logic signed [31:0]            i_key_value_x,
    input  logic signed [31:0]            i_key_value_y,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic                          o_sample_valid,
    output logic signed [31:0]            o_sample_x,
    output logic signed [31:0]            o_sample_y,
    output logic [1:0]                    o_status,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [kts_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    logic                          w_cmd_valid;
    logic                          w_cmd_ready;
    kts_pkg::t_cmd                 w_cmd;
    logic [$clog2(MAX_KEYS+1)-1:0] w_key_count;

    assign o_cfg_ready = 1'b1;

    kts_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_mode        (i_mode),
        .i_item_time   (i_item_time),
        .i_key_value_x (i_key_value_x),
        .i_key_value_y (i_key_value_y),
        .o_cmd_valid   (w_cmd_valid),
        .i_cmd_ready   (w_cmd_ready),
        .o_cmd         (w_cmd)
    );

    kts_back #(.MAX_KEYS(MAX_KEYS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd_valid    (w_cmd_valid),
        .o_cmd_ready    (w_cmd_ready),
        .i_cmd          (w_cmd),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_sample_valid (o_sample_valid),
        .o_sample_x     (o_sample_x),
        .o_sample_y     (o_sample_y),
        .o_status       (o_status),
        .o_key_count    (w_key_count)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_key_count <= ($clog2(MAX_KEYS+1))'(MAX_KEYS))
        else $error("key count beyond table size");

    a_status_no_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_status != kts_pkg::STATUS_OK) |-> !o_sample_valid)
        else $error("append status with a sample");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_sample_valid) |-> (o_sample_x == '0 && o_sample_y == '0))
        else $error("non-sample result carries a value");

    a_full_clear_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd_valid && w_cmd_ready && w_cmd.op == kts_pkg::OP_CLEAR) |=> w_key_count == '0)
        else $error("clear did not empty the table");

endmodule

// ===== dv/kts_checker.sv =====
`timescale 1ns / 1ps
module kts_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic                          i_full,
    input  logic [1:0]                    i_mode,
    input  logic [31:0]                   i_item_time,
    input  logic signed [31:0]            i_key_value_x,
    input  logic signed [31:0]            i_key_value_y,
    input  logic                          i_empty,
    input  logic                          i_pop,
    input  logic                          i_sample_valid,
    input  logic signed [31:0]            i_sample_x,
    input  logic signed [31:0]            i_sample_y,
    input  logic [1:0]                    i_status,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [kts_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_samples_seen,
    output int                            o_rejects_seen
);

    localparam int NKEYS = kts_pkg::MAX_KEYS_DEF;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [1:0]         status;
    } t_sample;

    logic [31:0] key_t [NKEYS];
    logic [31:0] key_x [NKEYS];
    logic [31:0] key_y [NKEYS];
    int          n_keys;
    logic        interp_on;
    logic        incl_on;
    t_sample     sample_fifo [$];

    function automatic logic [31:0] lerp(logic [31:0] a, logic [31:0] b,
                                         logic [16:0] frac);
        logic signed [33:0] d;
        logic [33:0]        mag;
        logic [50:0]        prod;
        logic signed [33:0] r;
        d    = $signed({{2{b[31]}}, b}) - $signed({{2{a[31]}}, a});
        mag  = d[33] ? -d : d;
        prod = mag * frac;
        r    = d[33] ? $signed({{2{a[31]}}, a}) - $signed({1'b0, prod[48:16]})
                     : $signed({{2{a[31]}}, a}) + $signed({1'b0, prod[48:16]});
        return r[31:0];
    endfunction

    function automatic t_sample sample_track(logic [1:0] mode, logic [31:0] t,
                                             logic [31:0] vx, logic [31:0] vy);
        t_sample     s;
        int          i;
        logic [63:0] span;
        logic [63:0] fr;
        logic [16:0] frac;
        s = '0;
        if (mode == kts_pkg::MODE_CLEAR) begin
            n_keys = 0;
        end else if (mode == kts_pkg::MODE_APPEND) begin
            if (n_keys >= NKEYS) begin
                s.status = kts_pkg::STATUS_FULL;
            end else if (n_keys > 0 && t < key_t[n_keys-1]) begin
                s.status = kts_pkg::STATUS_ORDER;
            end else begin
                key_t[n_keys] = t;
                key_x[n_keys] = vx;
                key_y[n_keys] = vy;
                n_keys++;
            end
        end else if (mode == kts_pkg::MODE_QUERY && n_keys > 0) begin
            for (i = 0; i < n_keys; i++)
                if (incl_on ? (t <= key_t[i]) : (t < key_t[i])) break;
            if (i == n_keys) begin
                s.valid = 1'b1;
                s.x = key_x[n_keys-1];
                s.y = key_y[n_keys-1];
            end else if (i > 0) begin
                s.valid = 1'b1;
                if (!interp_on) begin
                    s.x = key_x[i-1];
                    s.y = key_y[i-1];
                end else begin
                    frac = '0;
                    if (key_t[i] > key_t[i-1] && t >= key_t[i-1]) begin
                        span = {32'd0, key_t[i] - key_t[i-1]};
                        fr = ({32'd0, t - key_t[i-1]} << 16) / span;
                        frac = (fr > 64'd65536) ? 17'd65536 : fr[16:0];
                    end
                    s.x = lerp(key_x[i-1], key_x[i], frac);
                    s.y = lerp(key_y[i-1], key_y[i], frac);
                end
            end
        end
        return s;
    endfunction

    assign o_pending = sample_fifo.size();

    always @(posedge i_clk) begin
        t_sample e;
        if (!i_rst_n) begin
            n_keys = 0;
            interp_on = 1'b1;
            incl_on = 1'b0;
            sample_fifo.delete();
            o_fail_count = 0;
            o_samples_seen = 0;
            o_rejects_seen = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == kts_pkg::CFG_TRACK_KIND) interp_on = i_cfg_data[0];
                else if (i_cfg_index == kts_pkg::CFG_INCLUSIVE) incl_on = i_cfg_data[0];
            end
            if (i_pop && !i_empty) begin
                if (sample_fifo.size() == 0) begin
                    $error("result beat with nothing expected");
                    o_fail_count++;
                end else begin
                    e = sample_fifo.pop_front();
                    if (e.valid) o_samples_seen++;
                    if (e.status != kts_pkg::STATUS_OK) o_rejects_seen++;
                    if (i_sample_valid !== e.valid) begin
                        $error("sample_valid exp %0d got %0d", e.valid, i_sample_valid);
                        o_fail_count++;
                    end
                    if (i_sample_x !== e.x) begin
                        $error("sample_x exp %0d got %0d", e.x, i_sample_x);
                        o_fail_count++;
                    end
                    if (i_sample_y !== e.y) begin
                        $error("sample_y exp %0d got %0d", e.y, i_sample_y);
                        o_fail_count++;
                    end
                    if (i_status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, i_status);
                        o_fail_count++;
                    end
                end
            end
            if (i_push && !i_full)
                sample_fifo.push_back(sample_track(i_mode, i_item_time,
                                                   i_key_value_x, i_key_value_y));
        end
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

    localparam logic [kts_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 8'd9;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_push;
    logic                          o_full;
    logic [1:0]                    i_mode;
    logic [31:0]                   i_item_time;
    logic signed [31:0]            i_key_value_x;
    logic signed [31:0]            i_key_value_y;
    logic                          o_empty;
    logic                          i_pop;
    logic                          o_sample_valid;
    logic signed [31:0]            o_sample_x;
    logic signed [31:0]            o_sample_y;
    logic [1:0]                    o_status;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [kts_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]                   i_cfg_data;
    int                            fail_count;
    int                            pending;
    int                            samples_seen;
    int                            rejects_seen;
    int                            send_idle_pct;
    int                            pop_stall_pct;
    int                            beats_sent;
    logic [31:0]                   last_time;

    keyframe_track_sampler_top dut (.*);

    kts_checker u_chk (
        .i_clk, .i_rst_n, .i_push, .i_full(o_full), .i_mode, .i_item_time,
        .i_key_value_x, .i_key_value_y, .i_empty(o_empty), .i_pop,
        .i_sample_valid(o_sample_valid), .i_sample_x(o_sample_x),
        .i_sample_y(o_sample_y), .i_status(o_status), .i_cfg_valid,
        .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending),
        .o_samples_seen(samples_seen), .o_rejects_seen(rejects_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("simulation failed");
        $finish;
    end

    // receiver: random stall per cycle
    always @(negedge i_clk) begin
        i_pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    // push stays high after a beat so back-to-back items need no gap
    task automatic send_item(logic [1:0] mode, logic [31:0] t,
                             logic [31:0] vx, logic [31:0] vy);
        while ($urandom_range(99) < send_idle_pct) begin
            i_push <= 1'b0;
            @(negedge i_clk);
        end
        i_push <= 1'b1;
        i_mode <= mode;
        i_item_time <= t;
        i_key_value_x <= vx;
        i_key_value_y <= vy;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [kts_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random clears, appends (sometimes equal or unsorted times), queries and ignored items
    task automatic random_track(int n_items);
        int          k;
        int          r;
        logic [31:0] q;
        for (k = 0; k < n_items; k++) begin
            r = $urandom_range(99);
            if (r < 3) begin
                send_item(kts_pkg::MODE_CLEAR, $urandom, $urandom, $urandom);
                last_time = 0;
            end else if (r < 35) begin
                if ($urandom_range(9) == 0) q = $urandom;
                else if ($urandom_range(7) == 0) q = last_time;
                else q = last_time + $urandom_range(32'h0004_0000);
                if (q >= last_time) last_time = q;
                send_item(kts_pkg::MODE_APPEND, q, $urandom, $urandom);
            end else if (r < 97) begin
                case ($urandom_range(3))
                    0: q = $urandom;
                    1: q = last_time;
                    default: q = $urandom_range(last_time + 32'h10000);
                endcase
                send_item(kts_pkg::MODE_QUERY, q, $urandom, $urandom);
            end else begin
                send_item(kts_pkg::MODE_NONE, $urandom, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        int k;
        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_pop = 1'b0;
        i_mode = kts_pkg::MODE_CLEAR;
        i_item_time = '0;
        i_key_value_x = '0;
        i_key_value_y = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        beats_sent = 0;
        last_time = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, extremes, equal times, order reject, mode three
        send_item(kts_pkg::MODE_QUERY, 32'd5, '0, '0);
        send_item(kts_pkg::MODE_APPEND, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(kts_pkg::MODE_QUERY, 32'h0000_0000, '0, '0);
        send_item(kts_pkg::MODE_APPEND, 32'h0003_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(kts_pkg::MODE_QUERY, 32'h0002_0000, '0, '0);
        send_item(kts_pkg::MODE_QUERY, 32'h0001_0000, '0, '0);
        send_item(kts_pkg::MODE_QUERY, 32'h0003_0000, '0, '0);
        send_item(kts_pkg::MODE_APPEND, 32'h0003_0000, 32'd7, -32'sd7);
        send_item(kts_pkg::MODE_APPEND, 32'h0002_0000, 32'd1, 32'd1);
        send_item(kts_pkg::MODE_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        send_item(kts_pkg::MODE_QUERY, 32'hFFFF_FFFF, '0, '0);
        send_item(kts_pkg::MODE_QUERY, 32'hFFFF_FFFE, '0, '0);
        send_item(kts_pkg::MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        write_reg(kts_pkg::CFG_INCLUSIVE, 32'd1);
        send_item(kts_pkg::MODE_QUERY, 32'h0003_0000, '0, '0);
        send_item(kts_pkg::MODE_QUERY, 32'h0001_0000, '0, '0);
        write_reg(kts_pkg::CFG_TRACK_KIND, 32'd0);
        send_item(kts_pkg::MODE_QUERY, 32'h0002_8000, '0, '0);
        send_item(kts_pkg::MODE_CLEAR, '0, '0, '0);
        for (k = 0; k < 66; k++)
            send_item(kts_pkg::MODE_APPEND, 32'(k), $urandom, $urandom);
        send_item(kts_pkg::MODE_QUERY, 32'd70, '0, '0);
        send_item(kts_pkg::MODE_QUERY, 32'd30, '0, '0);
        write_reg(kts_pkg::CFG_TRACK_KIND, 32'd1);
        write_reg(kts_pkg::CFG_INCLUSIVE, 32'd0);
        write_reg(CFG_IDX_UNUSED, 32'hFFFF_FFFF);
        send_item(kts_pkg::MODE_QUERY, 32'd30, '0, '0);
        send_item(kts_pkg::MODE_CLEAR, '0, '0, '0);
        last_time = 0;

        // random phases across idling profiles and all register settings
        for (k = 0; k < 8; k++) begin
            case (k % 4)
                0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
                1: begin send_idle_pct = 85; pop_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  pop_stall_pct = 85; end
                default: begin send_idle_pct = 14; pop_stall_pct = 14; end
            endcase
            write_reg(kts_pkg::CFG_TRACK_KIND, {31'd0, k[0]});
            write_reg(kts_pkg::CFG_INCLUSIVE, {31'd0, k[1]});
            random_track(64);
        end

        i_push <= 1'b0;
        pop_stall_pct = 0;
        k = 0;
        while (pending != 0 && k < 100000) begin
            @(negedge i_clk);
            k++;
        end
        repeat (200) @(negedge i_clk);
        $display("sent %0d items; %0d valid samples, %0d rejected appends",
                 beats_sent, samples_seen, rejects_seen);
        $display("covered step/linear, strict/inclusive and four idling profiles");
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/kts_pkg.sv
rtl/kts_front.sv
rtl/kts_back.sv
rtl/keyframe_track_sampler_top.sv
dv/kts_checker.sv
dv/tb_top.sv
